[sv/odo_pkg.sv]
package odo_pkg;

  // field and state widths
  localparam int COUNT_WIDTH        = 32;
  localparam int POSITION_FRAC_BITS = 24;
  localparam int CORDIC_STAGES      = 24;

  localparam int TICK_W   = 32;
  localparam int POS_W    = 48;
  localparam int ANGLE_W  = 32;
  localparam int MPT_W    = 32;
  localparam int TPT_W    = 24;
  localparam int IN_W     = 4 * TICK_W;
  localparam int OUT_W    = 2 * POS_W + ANGLE_W;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // internal arithmetic widths
  localparam int SIDE_W       = COUNT_WIDTH + 1;
  localparam int TRAVEL_SHIFT = 33 - POSITION_FRAC_BITS;
  localparam int CORD_W       = 34;
  localparam int ATAN_IDX_W   = 5;
  localparam int STEP_W       = 51;
  localparam int MAG_W        = 65;

  localparam logic [MPT_W-1:0]         MPT_RESET  = 32'd1317678;
  localparam logic [TPT_W-1:0]         TPT_RESET  = 24'd699051;
  localparam logic signed [CORD_W-1:0] GAIN_START = 34'sh0_26DD_3B6A;
  localparam logic [MAG_W-1:0]         STEP_LIMIT = MAG_W'(1) << 49;
  localparam logic signed [STEP_W-1:0] POS_MAX_EXT =
    (STEP_W'(1) << (POS_W - 1)) - STEP_W'(1);
  localparam logic signed [STEP_W-1:0] POS_MIN_EXT = -(STEP_W'(1) << (POS_W - 1));

  // register map, byte address 4 * index
  typedef enum logic [0:0] {
    REG_METERS_PER_TICK = 1'b0,
    REG_TURN_PER_TICK   = 1'b1
  } reg_index_t;

  // sequencer states
  typedef enum logic [17:0] {
    ST_IDLE       = 18'h00001,
    ST_DELTA      = 18'h00002,
    ST_SIDE       = 18'h00004,
    ST_SUM        = 18'h00008,
    ST_MUL_TRAVEL = 18'h00010,
    ST_MUL_TURN   = 18'h00020,
    ST_ANGLE      = 18'h00040,
    ST_QUAD       = 18'h00080,
    ST_ROTATE     = 18'h00100,
    ST_FACTOR     = 18'h00200,
    ST_MXL        = 18'h00400,
    ST_MXH        = 18'h00800,
    ST_MYL        = 18'h01000,
    ST_MYH        = 18'h02000,
    ST_ADDX       = 18'h04000,
    ST_STEPY      = 18'h08000,
    ST_ADDY       = 18'h10000,
    ST_DONE       = 18'h20000
  } state_t;

  typedef struct packed {
    logic                       sat;
    logic signed [POS_W-1:0]    value;
  } sat_sum_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_unit(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // limit a step magnitude and give it its sign
  function automatic logic signed [STEP_W-1:0] clamp_step(input logic [MAG_W-1:0] mag,
                                                           input logic big,
                                                           input logic neg);
    logic [MAG_W-1:0] lim;
    lim = (big || (mag > STEP_LIMIT)) ? STEP_LIMIT : mag;
    return neg ? -STEP_W'(lim) : STEP_W'(lim);
  endfunction

  // saturating position add
  function automatic sat_sum_t sat_add(input logic signed [POS_W-1:0] a,
                                       input logic signed [STEP_W-1:0] b);
    logic signed [STEP_W-1:0] s;
    sat_sum_t r;
    s = STEP_W'(a) + b;
    if (s > POS_MAX_EXT) begin
      r.sat = 1'b1;
      r.value = POS_W'(POS_MAX_EXT);
    end else if (s < POS_MIN_EXT) begin
      r.sat = 1'b1;
      r.value = POS_W'(POS_MIN_EXT);
    end else begin
      r.sat = 1'b0;
      r.value = POS_W'(s);
    end
    return r;
  endfunction

endpackage

[sv/wheel_odometry_pose_update.sv]
// m_tvalid rises after delta, side, sum, travel and turn products, angle, quadrant, CORDIC
//   rotation, factor, x and y products and adds, and done; words are taken only in idle,
//   paced by the shared 32x32 multiplier, the one-stage-per-cycle CORDIC rotator and
//   the sequencer that drives both; the first word after reset only stores the counters
// reset (rst, synchronous): pose, heading and stored counters cleared, registers to defaults
module wheel_odometry_pose_update (
  input  logic                          clk,
  input  logic                          rst,
  // apb configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [odo_pkg::ADDR_W-1:0]    paddr,
  input  logic [odo_pkg::DATA_W-1:0]    pwdata,
  output logic [odo_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // input words
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // front_left_ticks, rear_left_ticks, front_right_ticks, rear_right_ticks
  input  logic [odo_pkg::IN_W-1:0]      s_tdata,
  // output words
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pos_x, pos_y, heading
  output logic [odo_pkg::OUT_W-1:0]     m_tdata,
  // pose_saturated
  output logic                          m_tuser
);
  import odo_pkg::*;

  state_t state;

  logic [MPT_W-1:0] meters_per_tick;
  logic [TPT_W-1:0] turn_per_tick;

  logic [COUNT_WIDTH-1:0]        count_cur [4];
  logic [COUNT_WIDTH-1:0]        count_prev [4];
  logic signed [COUNT_WIDTH-1:0] delta [4];
  logic                          primed;

  logic signed [SIDE_W-1:0] left_side;
  logic signed [SIDE_W-1:0] right_side;
  logic signed [SIDE_W-1:0] turn_diff;
  logic [SIDE_W-1:0]        sum_mag;
  logic                     sum_neg;

  logic [63:0]              travel;
  logic [ANGLE_W-1:0]       mid_angle;
  logic [ANGLE_W-1:0]       turn_lo;
  logic [1:0]               quad;

  logic signed [CORD_W-1:0] rx;
  logic signed [CORD_W-1:0] ry;
  logic signed [CORD_W-1:0] rz;
  logic [ATAN_IDX_W-1:0]    iter;

  logic [31:0]              fx;
  logic [31:0]              fy;
  logic                     x_neg;
  logic                     y_neg;

  logic [31:0]              mul_a;
  logic [31:0]              mul_b;
  logic [63:0]              prod;
  logic [33:0]              plo;
  logic [MAG_W-1:0]         pmag;
  logic                     pbig;
  logic signed [STEP_W-1:0] step;

  logic signed [POS_W-1:0]  x_position;
  logic signed [POS_W-1:0]  y_position;
  logic [ANGLE_W-1:0]       heading_angle;
  logic                     sat_flag;

  logic [POS_W-1:0]         out_x;
  logic [POS_W-1:0]         out_y;
  logic [ANGLE_W-1:0]       out_heading;
  logic                     out_sat;

  // combinational helpers
  logic signed [SIDE_W-1:0] left_sum;
  logic signed [SIDE_W-1:0] right_sum;
  logic signed [SIDE_W-1:0] side_total;
  logic [63:0]              travel_full;
  logic [32:0]              diff_ext;
  logic [32:0]              turn33;
  logic [1:0]               quad_next;
  logic [ANGLE_W-1:0]       z_start;
  logic signed [CORD_W-1:0] dx;
  logic signed [CORD_W-1:0] dy;
  logic signed [CORD_W-1:0] atan_step;
  logic signed [CORD_W-1:0] cos_val;
  logic signed [CORD_W-1:0] sin_val;
  logic signed [CORD_W-1:0] cos_abs;
  logic signed [CORD_W-1:0] sin_abs;
  logic [MAG_W-1:0]         pmag_next;
  sat_sum_t                 x_sum;
  sat_sum_t                 y_sum;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_METERS_PER_TICK: prdata = meters_per_tick;
      REG_TURN_PER_TICK:   prdata = DATA_W'(turn_per_tick);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meters_per_tick <= MPT_RESET;
      turn_per_tick   <= TPT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index_t'(paddr[2]))
        REG_METERS_PER_TICK: meters_per_tick <= pwdata;
        REG_TURN_PER_TICK:   turn_per_tick   <= pwdata[TPT_W-1:0];
        default: ;
      endcase
    end
  end

  // stream handshake
  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {out_heading, out_y, out_x};
  assign m_tuser  = out_sat;

  // side averages, truncated toward zero
  assign left_sum   = SIDE_W'(delta[0]) + SIDE_W'(delta[1]);
  assign right_sum  = SIDE_W'(delta[2]) + SIDE_W'(delta[3]);
  assign side_total = left_side + right_side;

  // travel and turn products
  assign travel_full = prod + (sum_mag[SIDE_W-1] ? (64'(meters_per_tick) << COUNT_WIDTH)
                                                  : 64'd0);
  assign diff_ext = 33'(turn_diff);
  assign turn33   = {prod[32] ^ (diff_ext[32] & turn_per_tick[0]), prod[31:0]};

  // quadrant reduction
  assign quad_next = 2'((mid_angle + 32'h2000_0000) >> 30);
  assign z_start   = mid_angle - {quad_next, 30'd0};

  // cordic stage
  assign dx        = ry >>> iter;
  assign dy        = rx >>> iter;
  assign atan_step = CORD_W'(atan_unit(iter));

  // quadrant mapping to cosine and sine
  always_comb begin
    case (quad)
      2'd0: begin
        cos_val = rx;
        sin_val = ry;
      end
      2'd1: begin
        cos_val = -ry;
        sin_val = rx;
      end
      2'd2: begin
        cos_val = -rx;
        sin_val = -ry;
      end
      default: begin
        cos_val = ry;
        sin_val = -rx;
      end
    endcase
    cos_abs = cos_val[CORD_W-1] ? -cos_val : cos_val;
    sin_abs = sin_val[CORD_W-1] ? -sin_val : sin_val;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_TRAVEL: begin
        mul_a = 32'(sum_mag[COUNT_WIDTH-1:0]);
        mul_b = meters_per_tick;
      end
      ST_MUL_TURN: begin
        mul_a = diff_ext[31:0];
        mul_b = 32'(turn_per_tick);
      end
      ST_MXL: begin
        mul_a = travel[31:0];
        mul_b = fx;
      end
      ST_MXH: begin
        mul_a = travel[63:32];
        mul_b = fx;
      end
      ST_MYL: begin
        mul_a = travel[31:0];
        mul_b = fy;
      end
      ST_MYH: begin
        mul_a = travel[63:32];
        mul_b = fy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // step magnitude from the high partial product and the held low part
  assign pmag_next = {1'b0, prod[61:0], 2'b00} + MAG_W'(plo);

  assign x_sum = sat_add(x_position, step);
  assign y_sum = sat_add(y_position, step);

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      primed        <= 1'b0;
      m_tvalid      <= 1'b0;
      x_position    <= '0;
      y_position    <= '0;
      heading_angle <= '0;
      for (int i = 0; i < 4; i++) begin
        count_prev[i] <= '0;
      end
    end else begin
      // output word taken; a pose waiting in done refills it
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < 4; i++) begin
              count_cur[i] <= s_tdata[i*TICK_W +: COUNT_WIDTH];
            end
            state <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          for (int i = 0; i < 4; i++) begin
            delta[i]      <= count_cur[i] - count_prev[i];
            count_prev[i] <= count_cur[i];
          end
          sat_flag <= 1'b0;
          primed   <= 1'b1;
          state    <= primed ? ST_SIDE : ST_DONE;
        end
        ST_SIDE: begin
          left_side  <= $signed(left_sum + SIDE_W'(left_sum[SIDE_W-1])) >>> 1;
          right_side <= $signed(right_sum + SIDE_W'(right_sum[SIDE_W-1])) >>> 1;
          state      <= ST_SUM;
        end
        ST_SUM: begin
          sum_neg   <= side_total[SIDE_W-1];
          sum_mag   <= side_total[SIDE_W-1] ? -side_total : side_total;
          turn_diff <= right_side - left_side;
          state     <= ST_MUL_TRAVEL;
        end
        ST_MUL_TRAVEL: begin
          state <= ST_MUL_TURN;
        end
        ST_MUL_TURN: begin
          travel <= travel_full >> TRAVEL_SHIFT;
          state  <= ST_ANGLE;
        end
        ST_ANGLE: begin
          mid_angle <= heading_angle + turn33[32:1];
          turn_lo   <= turn33[31:0];
          state     <= ST_QUAD;
        end
        ST_QUAD: begin
          quad  <= quad_next;
          rz    <= CORD_W'($signed(z_start));
          rx    <= GAIN_START;
          ry    <= '0;
          iter  <= '0;
          state <= ST_ROTATE;
        end
        ST_ROTATE: begin
          if (!rz[CORD_W-1]) begin
            rx <= rx - dx;
            ry <= ry + dy;
            rz <= rz - atan_step;
          end else begin
            rx <= rx + dx;
            ry <= ry - dy;
            rz <= rz + atan_step;
          end
          iter <= iter + ATAN_IDX_W'(1);
          if (iter == ATAN_IDX_W'(CORDIC_STAGES - 1)) begin
            state <= ST_FACTOR;
          end
        end
        ST_FACTOR: begin
          fx    <= cos_abs[31:0];
          fy    <= sin_abs[31:0];
          x_neg <= sum_neg ^ cos_val[CORD_W-1];
          y_neg <= sum_neg ^ sin_val[CORD_W-1];
          state <= ST_MXL;
        end
        ST_MXL: begin
          state <= ST_MXH;
        end
        ST_MXH: begin
          plo   <= 34'(prod >> 30);
          state <= ST_MYL;
        end
        ST_MYL: begin
          pbig  <= (prod[63:62] != 2'b00);
          pmag  <= pmag_next;
          state <= ST_MYH;
        end
        ST_MYH: begin
          plo   <= 34'(prod >> 30);
          step  <= clamp_step(pmag, pbig, x_neg);
          state <= ST_ADDX;
        end
        ST_ADDX: begin
          pbig       <= (prod[63:62] != 2'b00);
          pmag       <= pmag_next;
          x_position <= x_sum.value;
          sat_flag   <= x_sum.sat;
          state      <= ST_STEPY;
        end
        ST_STEPY: begin
          step  <= clamp_step(pmag, pbig, y_neg);
          state <= ST_ADDY;
        end
        ST_ADDY: begin
          y_position    <= y_sum.value;
          sat_flag      <= sat_flag | y_sum.sat;
          heading_angle <= heading_angle + turn_lo;
          state         <= ST_DONE;
        end
        ST_DONE: begin
          // hand the pose to the output register once it is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      out_x       <= x_position;
      out_y       <= y_position;
      out_heading <= heading_angle;
      out_sat     <= sat_flag;
    end
  end

endmodule
